[design/teletext_attribute_decoder_unit_macros.svh]
// assertion macros for the teletext attribute decoder
`ifndef TELETEXT_ATTRIBUTE_DECODER_UNIT_MACROS_SVH
`define TELETEXT_ATTRIBUTE_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TTAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TTAD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define TTAD_ASSERT(lbl, prop, msg)
`define TTAD_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[design/ttad_pkg.sv]
`default_nettype none

package ttad_pkg;

  typedef enum logic [1:0] {
    GS_ALPHA  = 2'd0,
    GS_CONTIG = 2'd1,
    GS_SEPAR  = 2'd2
  } glyph_set_e;

  // control codes
  localparam logic [6:0] CC_ALPHA_FIRST = 7'd1;
  localparam logic [6:0] CC_ALPHA_LAST  = 7'd7;
  localparam logic [6:0] CC_FLASH       = 7'd8;
  localparam logic [6:0] CC_STEADY      = 7'd9;
  localparam logic [6:0] CC_NORMAL_SIZE = 7'd12;
  localparam logic [6:0] CC_DOUBLE_SIZE = 7'd13;
  localparam logic [6:0] CC_GFX_FIRST   = 7'd17;
  localparam logic [6:0] CC_GFX_LAST    = 7'd23;
  localparam logic [6:0] CC_CONCEAL     = 7'd24;
  localparam logic [6:0] CC_CONTIGUOUS  = 7'd25;
  localparam logic [6:0] CC_SEPARATED   = 7'd26;
  localparam logic [6:0] CC_BLACK_BG    = 7'd28;
  localparam logic [6:0] CC_NEW_BG      = 7'd29;
  localparam logic [6:0] CC_HOLD        = 7'd30;
  localparam logic [6:0] CC_RELEASE     = 7'd31;

  localparam logic [6:0] CHAR_SPACE      = 7'h20;
  localparam logic [6:0] CHAR_CAPS_FIRST = 7'h40;
  localparam logic [6:0] CHAR_CAPS_LAST  = 7'h5F;
  localparam logic [5:0] LOWER_ROW_OFS   = 6'd10;
  localparam logic [2:0] COLOUR_WHITE    = 3'd7;
  localparam logic [2:0] COLOUR_BLACK    = 3'd0;

  typedef struct packed {
    logic       kind;
    logic [6:0] code;
    logic [5:0] scanline;
    logic       flash_on;
    logic       row_end;
  } item_t;

  typedef struct packed {
    logic       solid_fill;
    glyph_set_e glyph_set;
    logic [6:0] char_index;
    logic [5:0] glyph_row;
    logic [2:0] fg_colour;
    logic [2:0] bg_colour;
  } result_t;

  typedef struct packed {
    logic [2:0] fore_colour;
    logic [2:0] back_colour;
    logic       graphics_mode;
    logic       separated_mode;
    logic       flash_mode;
    logic       double_height;
    logic       double_seen_on_line;
    logic       hold_active;
    logic [6:0] held_code;
    glyph_set_e held_set;
    glyph_set_e next_set;
    logic       hold_clear_flag;
    logic       hold_off_flag;
    logic       lower_half_row;
  } attr_t;

endpackage

`default_nettype wire

[design/ttad_if.sv]
`default_nettype none

interface ttad_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [6:0] code;
  logic [5:0] scanline;
  logic       flash_on;
  logic       row_end;

  modport source (output valid, kind, code, scanline, flash_on, row_end, input ready);
  modport sink (input valid, kind, code, scanline, flash_on, row_end, output ready);
endinterface

interface ttad_out_if;
  logic       valid;
  logic       ready;
  logic       solid_fill;
  logic [1:0] glyph_set;
  logic [6:0] char_index;
  logic [5:0] glyph_row;
  logic [2:0] fg_colour;
  logic [2:0] bg_colour;

  modport source (output valid, solid_fill, glyph_set, char_index, glyph_row, fg_colour,
                  bg_colour, input ready);
  modport sink (input valid, solid_fill, glyph_set, char_index, glyph_row, fg_colour,
                bg_colour, output ready);
endinterface

`default_nettype wire

[design/ttad_attr_core.sv]
`default_nettype none

module ttad_attr_core import ttad_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire item_t   item_i,
  output result_t      result_o
);

  attr_t attr_q, attr_d;

  function automatic glyph_set_e sel_set(input logic gfx, input logic sep);
    glyph_set_e s;
    if (!gfx) begin
      s = GS_ALPHA;
    end else if (sep) begin
      s = GS_SEPAR;
    end else begin
      s = GS_CONTIG;
    end
    return s;
  endfunction

  logic [2:0] shown_fg;
  glyph_set_e cur_set;
  logic [6:0] shown_code;
  logic [5:0] row;
  logic       solid;

  always_comb begin
    attr_d     = attr_q;
    shown_fg   = attr_q.fore_colour;
    cur_set    = attr_q.next_set;
    shown_code = item_i.code;
    row        = item_i.scanline;
    solid      = 1'b0;

    if (item_i.kind) begin
      // end of scanline: line attributes back to defaults
      if (item_i.row_end) begin
        attr_d.lower_half_row = attr_q.lower_half_row ? 1'b0 : attr_q.double_seen_on_line;
      end
      attr_d.fore_colour         = COLOUR_WHITE;
      attr_d.back_colour         = COLOUR_BLACK;
      attr_d.graphics_mode       = 1'b0;
      attr_d.separated_mode      = 1'b0;
      attr_d.flash_mode          = 1'b0;
      attr_d.double_height       = 1'b0;
      attr_d.double_seen_on_line = 1'b0;
      attr_d.hold_active         = 1'b0;
      attr_d.held_code           = CHAR_SPACE;
      attr_d.held_set            = GS_ALPHA;
      attr_d.next_set            = GS_ALPHA;
    end else begin
      if (item_i.code < CHAR_SPACE) begin
        attr_d.hold_clear_flag = 1'b0;
        attr_d.hold_off_flag   = 1'b0;
        case (item_i.code) inside
          [CC_ALPHA_FIRST:CC_ALPHA_LAST]: begin
            attr_d.graphics_mode   = 1'b0;
            attr_d.fore_colour     = item_i.code[2:0];
            attr_d.next_set        = GS_ALPHA;
            attr_d.hold_clear_flag = 1'b1;
          end
          [CC_GFX_FIRST:CC_GFX_LAST]: begin
            attr_d.graphics_mode = 1'b1;
            attr_d.fore_colour   = item_i.code[2:0];
            attr_d.next_set      = sel_set(1'b1, attr_q.separated_mode);
          end
          CC_FLASH:       attr_d.flash_mode = 1'b1;
          CC_STEADY:      attr_d.flash_mode = 1'b0;
          CC_NORMAL_SIZE: attr_d.double_height = 1'b0;
          CC_DOUBLE_SIZE: begin
            attr_d.double_height       = 1'b1;
            attr_d.double_seen_on_line = 1'b1;
          end
          CC_CONCEAL: begin
            attr_d.fore_colour = attr_q.back_colour;
            shown_fg           = attr_q.back_colour;
          end
          CC_CONTIGUOUS: begin
            attr_d.separated_mode = 1'b0;
            attr_d.next_set       = sel_set(attr_q.graphics_mode, 1'b0);
          end
          CC_SEPARATED: begin
            attr_d.separated_mode = 1'b1;
            attr_d.next_set       = sel_set(attr_q.graphics_mode, 1'b1);
          end
          CC_BLACK_BG: attr_d.back_colour = COLOUR_BLACK;
          CC_NEW_BG:   attr_d.back_colour = attr_q.fore_colour;
          CC_HOLD:     attr_d.hold_active = 1'b1;
          CC_RELEASE:  attr_d.hold_off_flag = 1'b1;
          default: ;
        endcase
        // control cell shows a space or the held graphic
        if (attr_d.hold_active && (attr_d.double_height == attr_q.double_height)) begin
          shown_code = attr_q.held_code;
          if (attr_q.held_code inside {[CHAR_CAPS_FIRST:CHAR_CAPS_LAST]}) begin
            shown_code = CHAR_SPACE;
          end
          cur_set = attr_q.held_set;
        end else begin
          shown_code = CHAR_SPACE;
        end
      end else if (attr_q.graphics_mode) begin
        attr_d.held_code = item_i.code;
        attr_d.held_set  = attr_q.next_set;
      end

      if (attr_q.double_height) begin
        row = {1'b0, item_i.scanline[5:1]} + (attr_q.lower_half_row ? LOWER_ROW_OFS : 6'd0);
      end

      solid = (attr_q.flash_mode && item_i.flash_on) ||
              (attr_q.lower_half_row && !attr_d.double_height);

      if (attr_d.hold_off_flag) begin
        attr_d.hold_active = 1'b0;
        attr_d.held_code   = CHAR_SPACE;
      end
      if (attr_d.hold_clear_flag) begin
        attr_d.held_code = CHAR_SPACE;
      end
    end
  end

  always_comb begin
    result_o.bg_colour = attr_d.back_colour;
    if (solid) begin
      result_o.solid_fill = 1'b1;
      result_o.glyph_set  = GS_ALPHA;
      result_o.char_index = 7'd0;
      result_o.glyph_row  = 6'd0;
      result_o.fg_colour  = 3'd0;
    end else begin
      result_o.solid_fill = 1'b0;
      result_o.glyph_set  = cur_set;
      result_o.char_index = shown_code - CHAR_SPACE;
      result_o.glyph_row  = row;
      result_o.fg_colour  = shown_fg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q.fore_colour         <= COLOUR_WHITE;
      attr_q.back_colour         <= COLOUR_BLACK;
      attr_q.graphics_mode       <= 1'b0;
      attr_q.separated_mode      <= 1'b0;
      attr_q.flash_mode          <= 1'b0;
      attr_q.double_height       <= 1'b0;
      attr_q.double_seen_on_line <= 1'b0;
      attr_q.hold_active         <= 1'b0;
      attr_q.held_code           <= CHAR_SPACE;
      attr_q.held_set            <= GS_ALPHA;
      attr_q.next_set            <= GS_ALPHA;
      attr_q.hold_clear_flag     <= 1'b0;
      attr_q.hold_off_flag       <= 1'b0;
      attr_q.lower_half_row      <= 1'b0;
    end else if (step_i) begin
      attr_q <= attr_d;
    end
  end

endmodule

`default_nettype wire

[design/ttad_out_reg.sv]
`default_nettype none

module ttad_out_reg import ttad_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  ttad_out_if.source   out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.solid_fill = data_q.solid_fill;
  assign out_o.glyph_set  = data_q.glyph_set;
  assign out_o.char_index = data_q.char_index;
  assign out_o.glyph_row  = data_q.glyph_row;
  assign out_o.fg_colour  = data_q.fg_colour;
  assign out_o.bg_colour  = data_q.bg_colour;

endmodule

`default_nettype wire

[design/teletext_attribute_decoder_unit.sv]
// teletext serial attribute decoder
// in_i carries one request per character cell (kind 0) or per end of
// scanline (kind 1). every character cell gives one result on out_o: a glyph
// reference (set, index, row, colours) or a solid fill in the background
// colour; an end of scanline gives no result and resets the line attributes.
// a request is taken into an input register, then decoded against the
// attribute state as it leaves that register and written into the output
// register, which drives out_o. one request per cycle is sustained while out_o
// does not stall; the attribute registers see each request once, in order, in
// the cycle it moves out of the input register.
// when out_o stalls, the output register holds its result and the input
// register keeps one more request; end-of-scanline requests still drain.
// reset (rst_ni low, asynchronous) empties both registers and sets white on
// black, alphanumerics, no flash, no double height and no hold.
`default_nettype none
`include "teletext_attribute_decoder_unit_macros.svh"

module teletext_attribute_decoder_unit import ttad_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ttad_in_if.sink    in_i,
  ttad_out_if.source out_o
);

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    s1_adv;
  logic    out_free;
  logic    out_load;
  result_t result;

  assign s1_adv     = s1_valid_q && (s1_item_q.kind || out_free);
  assign out_load   = s1_adv && !s1_item_q.kind;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign s1_valid_d = (in_i.valid && in_i.ready) || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q.kind     <= in_i.kind;
      s1_item_q.code     <= in_i.code;
      s1_item_q.scanline <= in_i.scanline;
      s1_item_q.flash_on <= in_i.flash_on;
      s1_item_q.row_end  <= in_i.row_end;
    end
  end

  ttad_attr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  ttad_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

  `TTAD_ASSERT(a_solid_blank, (out_o.valid && out_o.solid_fill) |-> ((out_o.glyph_set == 2'd0) && (out_o.char_index == 7'd0) && (out_o.glyph_row == 6'd0) && (out_o.fg_colour == 3'd0)), "solid fill carries glyph data")
  `TTAD_ASSERT(a_set_legal, out_o.valid |-> (out_o.glyph_set != 2'd3), "illegal glyph set")
  `TTAD_ASSERT(a_index_range, out_o.valid |-> (out_o.char_index <= 7'd95), "glyph index out of range")
  `TTAD_ASSERT_NEXT(a_line_end_silent, (s1_adv && s1_item_q.kind && out_o.valid && !out_o.ready), $stable(out_o.char_index), "end of scanline disturbed a result")
  `TTAD_ASSERT_NEXT(a_cell_gives_result, out_load, out_o.valid, "character cell lost its result")

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ttad_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CHUNK_ITEMS = 240;
  localparam int IDLE_PCT = 14;

  logic clk_i = 1'b0;
  logic rst_ni;

  ttad_in_if in_if ();
  ttad_out_if out_if ();

  teletext_attribute_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  item_t   requests_pending[$];
  result_t cells_expected[$];
  attr_t   st;

  int  requests_queued = 0;
  int  requests_taken = 0;
  int  results_seen = 0;
  int  solid_fills = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_arm = 1'b0;
  bit  idle_en = 1'b1;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;

  // attribute state at the start of every scanline
  function automatic void line_defaults();
    st.fore_colour = COLOUR_WHITE;
    st.back_colour = COLOUR_BLACK;
    st.graphics_mode = 1'b0;
    st.separated_mode = 1'b0;
    st.flash_mode = 1'b0;
    st.double_height = 1'b0;
    st.double_seen_on_line = 1'b0;
    st.hold_active = 1'b0;
    st.held_code = CHAR_SPACE;
    st.held_set = GS_ALPHA;
    st.next_set = GS_ALPHA;
  endfunction

  function automatic bit decode_cell(input item_t it, output result_t res);
    logic [6:0] shown_code;
    logic [5:0] row;
    logic [2:0] shown_fg;
    logic       old_dbl;
    logic       prev_flash;
    glyph_set_e cur_set;
    res = '0;
    if (it.kind) begin
      if (it.row_end) st.lower_half_row = st.lower_half_row ? 1'b0 : st.double_seen_on_line;
      line_defaults();
      return 1'b0;
    end
    old_dbl = st.double_height;
    shown_fg = st.fore_colour;
    cur_set = st.next_set;
    prev_flash = st.flash_mode;
    shown_code = it.code;
    if (it.code < CHAR_SPACE) begin
      st.hold_clear_flag = 1'b0;
      st.hold_off_flag = 1'b0;
      if (it.code >= CC_ALPHA_FIRST && it.code <= CC_ALPHA_LAST) begin
        st.graphics_mode = 1'b0;
        st.fore_colour = it.code[2:0];
        st.hold_clear_flag = 1'b1;
      end else if (it.code >= CC_GFX_FIRST && it.code <= CC_GFX_LAST) begin
        st.graphics_mode = 1'b1;
        st.fore_colour = it.code[2:0];
      end else begin
        case (it.code)
          CC_FLASH:       st.flash_mode = 1'b1;
          CC_STEADY:      st.flash_mode = 1'b0;
          CC_NORMAL_SIZE: st.double_height = 1'b0;
          CC_DOUBLE_SIZE: begin
            st.double_height = 1'b1;
            st.double_seen_on_line = 1'b1;
          end
          CC_CONCEAL: begin
            st.fore_colour = st.back_colour;
            shown_fg = st.back_colour;
          end
          CC_CONTIGUOUS:  st.separated_mode = 1'b0;
          CC_SEPARATED:   st.separated_mode = 1'b1;
          CC_BLACK_BG:    st.back_colour = COLOUR_BLACK;
          CC_NEW_BG:      st.back_colour = st.fore_colour;
          CC_HOLD:        st.hold_active = 1'b1;
          CC_RELEASE:     st.hold_off_flag = 1'b1;
          default: ;
        endcase
      end
      st.next_set = !st.graphics_mode ? GS_ALPHA : (st.separated_mode ? GS_SEPAR : GS_CONTIG);
      if (st.hold_active && st.double_height == old_dbl) begin
        shown_code = st.held_code;
        if (shown_code >= CHAR_CAPS_FIRST && shown_code <= CHAR_CAPS_LAST) shown_code = CHAR_SPACE;
        cur_set = st.held_set;
      end else begin
        shown_code = CHAR_SPACE;
      end
    end else if (st.graphics_mode) begin
      st.held_code = it.code;
      st.held_set = cur_set;
    end
    row = it.scanline;
    if (old_dbl) begin
      row = row >> 1;
      if (st.lower_half_row) row = row + LOWER_ROW_OFS;
    end
    if ((prev_flash && it.flash_on) || (st.lower_half_row && !st.double_height)) begin
      res.solid_fill = 1'b1;
    end else begin
      res.glyph_set = cur_set;
      res.char_index = shown_code - CHAR_SPACE;
      res.glyph_row = row;
      res.fg_colour = shown_fg;
    end
    res.bg_colour = st.back_colour;
    if (st.hold_off_flag) begin
      st.hold_active = 1'b0;
      st.held_code = CHAR_SPACE;
    end
    if (st.hold_clear_flag) st.held_code = CHAR_SPACE;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [6:0] want_v,
                                      input logic [6:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endfunction

  task automatic offer(input bit k, input logic [6:0] c, input logic [5:0] s, input bit f,
                       input bit r);
    item_t it;
    it.kind = k;
    it.code = c;
    it.scanline = s;
    it.flash_on = f;
    it.row_end = r;
    requests_pending.push_back(it);
    requests_queued++;
  endtask

  // random scanlines of cells closed by an end of scanline, with some noise
  task automatic queue_lines(input int n);
    int added;
    int len;
    int pick;
    logic [6:0] c;
    added = 0;
    while (added < n) begin
      len = $urandom_range(1, 40);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) c = 7'($urandom_range(0, 31));
        else if (pick < 50) c = 7'($urandom_range(64, 95));
        else c = 7'($urandom_range(32, 127));
        offer($urandom_range(0, 99) < 8, c, 6'($urandom_range(0, 63)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        added++;
      end
      offer(1'b1, 7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      added++;
    end
  endtask

  task automatic settle(input bit for_results);
    while (requests_taken != requests_queued) @(posedge clk_i);
    if (for_results) while (cells_expected.size() != 0) @(posedge clk_i);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (requests_pending.size() != 0 && !(idle_en && $urandom_range(0, 99) < IDLE_PCT)) begin
        in_if.valid <= 1'b1;
        {in_if.kind, in_if.code, in_if.scanline, in_if.flash_on, in_if.row_end} <=
          requests_pending.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_arm) begin
      hold_arm = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    item_t   seen;
    result_t want;
    if (rst_ni) begin
      in_taken = in_if.valid && in_if.ready;
      out_taken = out_if.valid && out_if.ready;
      if (in_taken) begin
        seen = {in_if.kind, in_if.code, in_if.scanline, in_if.flash_on, in_if.row_end};
        requests_taken++;
        if (decode_cell(seen, want)) begin
          cells_expected.push_back(want);
          if (want.solid_fill) solid_fills++;
        end
      end
      if (out_taken) begin
        results_seen++;
        if (cells_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got fill %0b index %0d", $time,
                   out_if.solid_fill, out_if.char_index);
        end else begin
          want = cells_expected.pop_front();
          check_field("solid_fill", 7'(want.solid_fill), 7'(out_if.solid_fill));
          check_field("glyph_set", 7'(want.glyph_set), 7'(out_if.glyph_set));
          check_field("char_index", want.char_index, out_if.char_index);
          check_field("glyph_row", 7'(want.glyph_row), 7'(out_if.glyph_row));
          check_field("fg_colour", 7'(want.fg_colour), 7'(out_if.fg_colour));
          check_field("bg_colour", 7'(want.bg_colour), 7'(out_if.bg_colour));
        end
      end
      quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.code = '0;
    in_if.scanline = '0;
    in_if.flash_on = 1'b0;
    in_if.row_end = 1'b0;
    out_if.ready = 1'b0;
    line_defaults();
    st.hold_clear_flag = 1'b0;
    st.hold_off_flag = 1'b0;
    st.lower_half_row = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    offer(1'b0, CHAR_SPACE, 6'd0, 1'b0, 1'b0);
    offer(1'b0, 7'h7F, 6'd63, 1'b1, 1'b1);
    offer(1'b0, 7'd0, 6'd1, 1'b0, 1'b0);
    offer(1'b0, CC_ALPHA_FIRST, 6'd2, 1'b0, 1'b0);
    offer(1'b0, CC_GFX_LAST, 6'd3, 1'b0, 1'b0);
    offer(1'b0, 7'h45, 6'd4, 1'b0, 1'b0);
    offer(1'b0, CC_HOLD, 6'd5, 1'b0, 1'b0);
    offer(1'b0, 7'h7F, 6'd6, 1'b0, 1'b0);
    offer(1'b0, CC_SEPARATED, 6'd7, 1'b0, 1'b0);
    offer(1'b0, 7'h60, 6'd8, 1'b0, 1'b0);
    offer(1'b0, CC_CONTIGUOUS, 6'd9, 1'b0, 1'b0);
    offer(1'b0, CC_NEW_BG, 6'd10, 1'b0, 1'b0);
    offer(1'b0, CC_CONCEAL, 6'd11, 1'b0, 1'b0);
    offer(1'b0, CC_BLACK_BG, 6'd12, 1'b0, 1'b0);
    offer(1'b0, CC_RELEASE, 6'd13, 1'b0, 1'b0);
    offer(1'b0, 7'h41, 6'd14, 1'b0, 1'b0);
    offer(1'b0, CC_FLASH, 6'd15, 1'b1, 1'b0);
    offer(1'b0, 7'h42, 6'd16, 1'b1, 1'b0);
    offer(1'b0, CC_STEADY, 6'd17, 1'b1, 1'b0);
    offer(1'b0, CC_DOUBLE_SIZE, 6'd63, 1'b0, 1'b0);
    offer(1'b0, 7'h43, 6'd37, 1'b0, 1'b0);
    offer(1'b1, 7'h7F, 6'd63, 1'b1, 1'b1);
    offer(1'b0, 7'h44, 6'd5, 1'b0, 1'b0);
    offer(1'b0, CC_DOUBLE_SIZE, 6'd63, 1'b0, 1'b0);
    offer(1'b0, 7'h44, 6'd20, 1'b0, 1'b0);
    offer(1'b1, 7'd0, 6'd0, 1'b0, 1'b1);
    offer(1'b1, 7'h7F, 6'd63, 1'b1, 1'b0);
    settle(1'b1);

    for (int chunk = 0; chunk < 7; chunk++) begin
      settle(1'b0);
      // one chunk runs with no idling on either side
      idle_en = (chunk != 3);
      if (chunk == 1) hold_arm = 1'b1;
      queue_lines(CHUNK_ITEMS);
      if (chunk == 4) settle(1'b1);
    end
    settle(1'b1);
    repeat (8) @(posedge clk_i);

    $display("ran %0d requests: directed attribute codes, then random scanlines with noise",
             requests_taken);
    $display("checked %0d cell results (%0d solid fills), %0d mismatches", results_seen,
             solid_fills, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/ttad_pkg.sv
design/ttad_if.sv
design/ttad_attr_core.sv
design/ttad_out_reg.sv
design/teletext_attribute_decoder_unit.sv
test/tb_top.sv
